### design/ple_pkg.sv
// Shared types, sizes and codes for the positional list engine.
`default_nettype none
package ple_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = CAPACITY / GROUP_SIZE;
    localparam int OFF_W      = $clog2(GROUP_SIZE);
    localparam int GRP_W      = $clog2(NUM_GROUPS);

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_SET    = 3'd2;
    localparam logic [2:0] ACT_REMOVE = 3'd3;
    localparam logic [2:0] ACT_GET    = 3'd4;
    localparam logic [2:0] ACT_FIND   = 3'd5;
    localparam logic [2:0] ACT_CLEAR  = 3'd6;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_WRITE  = 2'd1;
    localparam logic [1:0] CELL_INSERT = 2'd2;
    localparam logic [1:0] CELL_REMOVE = 2'd3;

    typedef struct packed {
        logic [2:0]              action;
        logic [CNT_W-1:0]        position;
        logic signed [DATA_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [IDX_W-1:0]         found_position;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  sel_idx;
    } cell_probe_t;

    typedef struct packed {
        logic              any_match;
        logic [OFF_W-1:0]  match_off;
        logic [DATA_W-1:0] sel_value;
    } grp_t;

endpackage
`default_nettype wire

### design/positional_list_engine.sv
// Top level of the positional list engine: control, cell row and result register.
//
// Input channel s_valid/s_ready/s_data carries one action (add, insert, set,
// remove, get, find, clear) with a position and a value. Output channel
// m_valid/m_ready/m_data returns one result per action: ok, read value,
// found position, count, emptiness, front and back after the action.
//
// The result is presented after a registered pass through the grouped cell
// reduction for the position and search lookup, the update of the cell row,
// and a second pass through the same reduction to read the new back element.
// One action is in flight at a time, so no new transfer is taken until the
// previous result sits in the output register; the next transfer is taken
// as soon as it does, even while that result is still waiting for m_ready.
//
// Reset empties the list; cell contents are not cleared. When the receiver
// stalls, a finished result holds in the output register and the following
// action waits at its last step until the register frees up.
`default_nettype none
module positional_list_engine
    import ple_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GRP  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_BGRP = 3'd3;
    localparam logic [2:0] ST_BRED = 3'd4;

    logic [2:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ok_reg, ok_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic [IDX_W-1:0] found_reg, found_next;
    logic             m_valid_reg;
    rsp_t             out_reg;

    cell_cmd_t   cmd;
    cell_probe_t probe;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
    logic [CAPACITY-1:0]             cell_match;
    logic [CAPACITY-1:0]             cell_sel;
    grp_t [NUM_GROUPS-1:0]           grp;

    logic              any_match;
    logic [IDX_W-1:0]  match_idx;
    logic [DATA_W-1:0] sel_value;
    logic              pos_valid;
    logic              not_full;
    logic              finish;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign probe.key     = req_reg.data_value;
    assign probe.count   = count_reg;
    assign probe.sel_idx = (state_reg == ST_GRP) ? req_reg.position : count_reg - 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_W-1:0] left_v;
            logic [DATA_W-1:0] right_v;
            if (gi == 0) begin : g_first
                assign left_v = cell_value[gi];
            end else begin : g_mid_l
                assign left_v = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_v = cell_value[gi];
            end else begin : g_mid_r
                assign right_v = cell_value[gi+1];
            end
            ple_cell u_cell (
                .aclk       (aclk),
                .cell_index (IDX_W'(gi)),
                .cmd        (cmd),
                .probe      (probe),
                .left_value (left_v),
                .right_value(right_v),
                .value      (cell_value[gi]),
                .match      (cell_match[gi]),
                .sel        (cell_sel[gi])
            );
        end
        for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_group
            ple_group u_group (
                .aclk  (aclk),
                .values(cell_value[gi*GROUP_SIZE +: GROUP_SIZE]),
                .match (cell_match[gi*GROUP_SIZE +: GROUP_SIZE]),
                .sel   (cell_sel[gi*GROUP_SIZE +: GROUP_SIZE]),
                .grp   (grp[gi])
            );
        end
    endgenerate

    always_comb begin
        any_match = 1'b0;
        match_idx = '0;
        sel_value = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (grp[g].any_match) begin
                any_match = 1'b1;
                match_idx = {GRP_W'(g), grp[g].match_off};
            end
        end
        for (int g = 0; g < NUM_GROUPS; g++) begin
            sel_value = sel_value | grp[g].sel_value;
        end
    end

    assign pos_valid = (req_reg.position < count_reg);
    assign not_full  = (count_reg < CNT_W'(CAPACITY));
    assign finish    = (state_reg == ST_BRED) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd        = '{op: CELL_HOLD, pos: req_reg.position, data: req_reg.data_value};
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        found_next = '0;
        if (state_reg == ST_RED) begin
            unique case (req_reg.action)
                ACT_ADD: begin
                    if (not_full) begin
                        cmd.op     = CELL_WRITE;
                        cmd.pos    = count_reg;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                ACT_INSERT: begin
                    if (not_full && req_reg.position <= count_reg) begin
                        cmd.op     = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                        ok_next    = 1'b1;
                    end
                end
                ACT_SET: begin
                    if (pos_valid) begin
                        cmd.op  = CELL_WRITE;
                        ok_next = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (pos_valid) begin
                        cmd.op     = CELL_REMOVE;
                        count_next = count_reg - 1'b1;
                        rd_next    = sel_value;
                        ok_next    = 1'b1;
                    end
                end
                ACT_GET: begin
                    if (pos_valid) begin
                        rd_next = sel_value;
                        ok_next = 1'b1;
                    end
                end
                ACT_FIND: begin
                    ok_next    = any_match;
                    found_next = any_match ? match_idx : '0;
                end
                ACT_CLEAR: begin
                    count_next = '0;
                    ok_next    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_GRP;
            ST_GRP:  state_next = ST_RED;
            ST_RED:  state_next = ST_BGRP;
            ST_BGRP: state_next = ST_BRED;
            ST_BRED: if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (finish) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        if (state_reg == ST_RED) begin
            ok_reg    <= ok_next;
            rd_reg    <= rd_next;
            found_reg <= found_next;
        end
        if (finish) begin
            out_reg.ok             <= ok_reg;
            out_reg.read_value     <= rd_reg;
            out_reg.found_position <= found_reg;
            out_reg.count          <= count_reg;
            out_reg.is_empty       <= (count_reg == '0);
            out_reg.front_value    <= (count_reg == '0) ? '0 : cell_value[0];
            out_reg.back_value     <= (count_reg == '0) ? '0 : sel_value;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_GRP))
        else $error("transfer did not start lookup pass");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED && req_reg.action == ACT_REMOVE && pos_valid)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not shrink the list");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.count == '0)))
        else $error("empty flag disagrees with count");

endmodule
`default_nettype wire

### design/ple_cell.sv
// One list cell: holds an element, shifts with its neighbors, compares and selects.
`default_nettype none
module ple_cell
    import ple_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire cell_cmd_t         cmd,
    input  wire cell_probe_t       probe,
    input  wire logic [DATA_W-1:0] left_value,
    input  wire logic [DATA_W-1:0] right_value,
    output logic [DATA_W-1:0]      value,
    output logic                   match,
    output logic                   sel
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [CNT_W-1:0]  idx;

    assign idx   = CNT_W'(cell_index);
    assign value = value_reg;
    assign match = (value_reg == probe.key) && (idx < probe.count);
    assign sel   = (idx == probe.sel_idx);

    always_comb begin
        value_next = value_reg;
        unique case (cmd.op)
            CELL_HOLD: begin
                value_next = value_reg;
            end
            CELL_WRITE: begin
                if (idx == cmd.pos) value_next = cmd.data;
            end
            CELL_INSERT: begin
                if (idx > cmd.pos) value_next = left_value;
                else if (idx == cmd.pos) value_next = cmd.data;
            end
            CELL_REMOVE: begin
                if (idx >= cmd.pos) value_next = right_value;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule
`default_nettype wire

### design/ple_group.sv
// Registered reduction of one group of cells: first match and selected value.
`default_nettype none
module ple_group
    import ple_pkg::*;
(
    input  wire logic                                aclk,
    input  wire logic [GROUP_SIZE-1:0][DATA_W-1:0]   values,
    input  wire logic [GROUP_SIZE-1:0]               match,
    input  wire logic [GROUP_SIZE-1:0]               sel,
    output grp_t                                     grp
);

    grp_t grp_reg;
    grp_t grp_next;

    assign grp = grp_reg;

    always_comb begin
        grp_next = '0;
        for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (match[k]) begin
                grp_next.any_match = 1'b1;
                grp_next.match_off = OFF_W'(k);
            end
        end
        for (int k = 0; k < GROUP_SIZE; k++) begin
            grp_next.sel_value = grp_next.sel_value | (values[k] & {DATA_W{sel[k]}});
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

endmodule
`default_nettype wire
